### design/wap_pkg.sv
// ----------------------------------------------------------------------------
// wap_pkg
// Shared sizes, codes and transaction types for the waveform autoscale block.
// ----------------------------------------------------------------------------
package wap_pkg;

	localparam int PERIOD_POINTS = 256;
	localparam int FRAME_POINTS  = 3 * PERIOD_POINTS;
	localparam int CNT_W         = $clog2(FRAME_POINTS + 1);
	localparam int ADDR_W        = $clog2(FRAME_POINTS);
	localparam int SAMPLE_W      = 16;
	localparam int PIX_W         = 8;
	localparam int PROD_W        = SAMPLE_W + PIX_W;
	localparam int STEP_W        = $clog2(PIX_W);
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 8;

	localparam logic [CNT_W-1:0] FRAME_CNT   = CNT_W'(FRAME_POINTS);
	localparam logic [CNT_W-1:0] PERIOD_CNT  = CNT_W'(PERIOD_POINTS);
	localparam logic [CNT_W-1:0] PERIOD2_CNT = CNT_W'(2 * PERIOD_POINTS);

	localparam logic [PIX_W-1:0]           HEIGHT_RESET = 8'd210;
	localparam logic signed [SAMPLE_W-1:0] MIN_RESET    = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] MAX_RESET    = -16'sd32767;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EMIT = 1'b1;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last_pixel;
	} out_item_t;

	typedef struct packed {
		logic                       start;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0]        span;
		logic [PIX_W-1:0]           height;
	} scale_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] pixel;
	} scale_rsp_t;

endpackage

### design/wap_ram.sv
// ----------------------------------------------------------------------------
// wap_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/wap_scale.sv
// ----------------------------------------------------------------------------
// wap_scale
// Pixel scaler: subtract, multiply by height, then an 8-step restoring divide
// by the span with a final clamp to the height.
// ----------------------------------------------------------------------------
module wap_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  wap_pkg::scale_req_t req,
	output wap_pkg::scale_rsp_t rsp
);
	import wap_pkg::*;

	typedef enum logic [4:0] {
		SC_IDLE = 5'b00001,
		SC_MUL  = 5'b00010,
		SC_PRE  = 5'b00100,
		SC_DIV  = 5'b01000,
		SC_FIN  = 5'b10000
	} sc_state_t;

	sc_state_t           state_q;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;
	logic [SAMPLE_W-1:0] diff_q;
	logic [SAMPLE_W-1:0] span_q;
	logic [PIX_W-1:0]    h_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [PIX_W-1:0]    quo_q;
	logic                ovf_q;
	logic [PIX_W-1:0]    pixel_q;

	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W:0]   trial;
	logic [SAMPLE_W:0]   trial_sub;
	logic                fits;
	logic [SAMPLE_W-1:0] rem_nxt;

	assign diff      = req.sample - req.min;
	assign trial     = {rem_q, quo_q[PIX_W-1]};
	assign trial_sub = trial - {1'b0, span_q};
	assign fits      = trial >= {1'b0, span_q};
	assign rem_nxt   = fits ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					state_q <= SC_PRE;
				end
				SC_PRE: begin
					step_q  <= '0;
					state_q <= SC_DIV;
				end
				SC_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(PIX_W - 1)) begin
						state_q <= SC_FIN;
					end
				end
				SC_FIN: begin
					done_q  <= 1'b1;
					state_q <= SC_IDLE;
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				diff_q <= diff;
				span_q <= req.span;
				h_q    <= req.height;
			end
			SC_MUL: begin
				prod_q <= PROD_W'(diff_q) * PROD_W'(h_q);
			end
			SC_PRE: begin
				ovf_q <= prod_q[PROD_W-1:PIX_W] >= span_q;
				rem_q <= prod_q[PROD_W-1:PIX_W];
				quo_q <= prod_q[PIX_W-1:0];
			end
			SC_DIV: begin
				rem_q <= rem_nxt;
				quo_q <= {quo_q[PIX_W-2:0], fits};
			end
			SC_FIN: begin
				pixel_q <= (ovf_q || quo_q > h_q) ? h_q : quo_q;
			end
			default: begin
				pixel_q <= pixel_q;
			end
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.pixel = pixel_q;

endmodule

### design/waveform_autoscale_to_plot.sv
// ----------------------------------------------------------------------------
// waveform_autoscale_to_plot
// Loads a three-period frame, keeps the window in RAM with its min and max,
// and returns one scaled pixel per emit transaction on a full frame.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data  (kind, sample)
//   out     | output    | out_valid / out_ready | out_data (pixel, last_pixel)
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A load transaction leaves the input ready; so does an emit before the frame is full.
// An emit on a full frame holds the input until its pixel is registered at the output:
// RAM read, subtract, multiply, range check, eight divider steps, clamp,
// state handoff and output register.
// One transaction is in work at once.
// Reset clears counters and min/max and sets config to its reset values; the RAM needs no clearing pass.
// A stalled output holds its result; the input is still taken until a second pixel must wait for it.
// ----------------------------------------------------------------------------
module waveform_autoscale_to_plot (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wap_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output wap_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [wap_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wap_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wap_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_CALC  = 4'b0100,
		S_PUSH  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic                       mode_cfg_q;
	logic [PIX_W-1:0]           height_q;
	logic                       win_mode_q;
	logic [CNT_W-1:0]           load_cnt_q;
	logic [ADDR_W-1:0]          rd_idx_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic signed [SAMPLE_W-1:0] min_s1;
	logic [SAMPLE_W-1:0]        span_s1;
	logic [PIX_W-1:0]           h_s1;
	logic                       last_s1;

	logic                       frame_full;
	logic                       ld_fire;
	logic                       em_fire;
	logic                       push_fire;
	logic                       mode_now;
	logic                       in_win;
	logic [CNT_W-1:0]           wr_pos;
	logic [CNT_W-1:0]           win_len;
	logic [ADDR_W-1:0]          rd_idx;
	logic                       emit_last;
	logic [SAMPLE_W:0]          span_raw;
	logic [SAMPLE_W-1:0]        span;
	logic                       ram_we;
	logic [SAMPLE_W-1:0]        ram_rdata;
	scale_req_t                 req;
	scale_rsp_t                 rsp;

	assign in_ready   = (state_q == S_IDLE);
	assign frame_full = (load_cnt_q == FRAME_CNT);
	assign ld_fire    = in_valid && in_ready && (in_data.kind == KIND_LOAD) && !frame_full;
	assign em_fire    = in_valid && in_ready && (in_data.kind == KIND_EMIT) && frame_full;
	assign push_fire  = (state_q == S_PUSH) && (!out_valid_q || out_ready);

	assign mode_now = (load_cnt_q == '0) ? mode_cfg_q : win_mode_q;
	assign in_win   = !mode_now || (load_cnt_q >= PERIOD_CNT && load_cnt_q < PERIOD2_CNT);
	assign wr_pos   = mode_now ? (load_cnt_q - PERIOD_CNT) : load_cnt_q;
	assign ram_we   = ld_fire && in_win;

	assign win_len   = win_mode_q ? PERIOD_CNT : FRAME_CNT;
	assign rd_idx    = (CNT_W'(rd_idx_q) >= win_len) ? '0 : rd_idx_q;
	assign emit_last = (CNT_W'(rd_idx) + CNT_W'(1)) >= win_len;

	assign span_raw = {max_q[SAMPLE_W-1], max_q} - {min_q[SAMPLE_W-1], min_q};
	assign span     = (span_raw[SAMPLE_W-1:0] == '0) ? SAMPLE_W'(1) : span_raw[SAMPLE_W-1:0];

	wap_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(FRAME_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_pos[ADDR_W-1:0]),
		.wdata (in_data.sample),
		.re    (em_fire),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	assign req.start  = (state_q == S_FETCH);
	assign req.sample = ram_rdata;
	assign req.min    = min_s1;
	assign req.span   = span_s1;
	assign req.height = h_s1;

	wap_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_cfg_q  <= 1'b0;
			height_q    <= HEIGHT_RESET;
			win_mode_q  <= 1'b0;
			load_cnt_q  <= '0;
			rd_idx_q    <= '0;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_cfg_q <= cfg_data[0];
					REG_HEIGHT: height_q   <= cfg_data;
					default:    height_q   <= height_q;
				endcase
			end

			if (ld_fire) begin
				load_cnt_q <= load_cnt_q + 1'b1;
				if (load_cnt_q == '0) begin
					win_mode_q <= mode_cfg_q;
				end
				if (in_win) begin
					if (in_data.sample > max_q) begin
						max_q <= in_data.sample;
					end
					if (in_data.sample < min_q) begin
						min_q <= in_data.sample;
					end
				end
			end

			if (em_fire) begin
				if (emit_last) begin
					load_cnt_q <= '0;
					rd_idx_q   <= '0;
					min_q      <= MIN_RESET;
					max_q      <= MAX_RESET;
				end else begin
					rd_idx_q <= rd_idx + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (em_fire) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture scaling operands before the frame clears
	always_ff @(posedge clk) begin
		if (em_fire) begin
			min_s1  <= min_q;
			span_s1 <= span;
			h_s1    <= height_q;
			last_s1 <= emit_last;
		end
		if (push_fire) begin
			out_q.pixel      <= rsp.pixel;
			out_q.last_pixel <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(em_fire && emit_last) |=> (load_cnt_q == '0 && rd_idx_q == '0))
		else $error("frame not cleared after last pixel");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == S_CALC))
		else $error("scaler result outside calc state");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		frame_full |-> (max_q >= min_q))
		else $error("running max below running min on full frame");

endmodule

### tb/sv/waveform_autoscale_to_plot_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// waveform_autoscale_to_plot_tb
// Self-checking bench for the waveform autoscale block. It loads whole frames
// in both window modes and at several plot heights, then requests every pixel.
// A built-in scaler predicts each pixel as the block should return it. Each
// returned pixel is checked against that prediction. Idle cycles on the input
// side and stalls on the output side come and go in rotating phases.
// ---------------------------------------------------------------------------
module waveform_autoscale_to_plot_tb;
	import wap_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASE_LEN    = 97;
	localparam int LATENCY_PAD  = 20;
	localparam int PH_NONE      = 0;
	localparam int PH_SEND      = 1;
	localparam int PH_RECV      = 2;
	localparam int PH_BOTH      = 3;

	typedef enum int {FILL_UNIFORM, FILL_NARROW, FILL_FLAT, FILL_MOST_NEG} fill_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [SAMPLE_W-1:0] win_store [FRAME_POINTS];
	int unsigned frame_loads;
	int unsigned read_pos;
	int          win_min;
	int          win_max;
	bit          win_mode;
	bit          cfg_mode;
	int unsigned cfg_height;

	out_item_t expected_pixels [$];
	int        n_sent;
	int        n_pixels;
	int        n_mismatch;
	int        idle_phase;
	int        frames_by_mode [2];

	waveform_autoscale_to_plot dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned window_len(input bit mode);
		return mode ? PERIOD_POINTS : FRAME_POINTS;
	endfunction

	function automatic void clear_window();
		frame_loads = 0;
		read_pos    = 0;
		win_min     = 32767;
		win_max     = -32767;
	endfunction

	function automatic bit predict_pixel(input in_item_t it, output out_item_t px);
		int          v;
		int unsigned offset;
		int unsigned len;
		int unsigned span;
		int unsigned diff;
		int unsigned y;
		px = '0;
		if (it.kind == KIND_LOAD) begin
			if (frame_loads >= FRAME_POINTS)
				return 1'b0;
			if (frame_loads == 0)
				win_mode = cfg_mode;
			v = it.sample;
			offset = win_mode ? PERIOD_POINTS : 0;
			len = window_len(win_mode);
			if (frame_loads >= offset && frame_loads - offset < len) begin
				win_store[frame_loads - offset] = it.sample;
				if (v > win_max)
					win_max = v;
				if (v < win_min)
					win_min = v;
			end
			frame_loads++;
			if (frame_loads == FRAME_POINTS)
				frames_by_mode[win_mode]++;
			return 1'b0;
		end
		if (frame_loads < FRAME_POINTS)
			return 1'b0;
		len = window_len(win_mode);
		if (read_pos >= len)
			read_pos = 0;
		v = win_store[read_pos];
		span = win_max - win_min;
		if (span == 0)
			span = 1;
		diff = (v - win_min) & 32'hFFFF;
		y = diff * cfg_height / span;
		if (y > cfg_height)
			y = cfg_height;
		px.pixel      = PIX_W'(y);
		px.last_pixel = (read_pos + 1 >= len);
		if (px.last_pixel)
			clear_window();
		else
			read_pos++;
		return 1'b1;
	endfunction

	function automatic void flag_mismatch(input string what, input int want, input int got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("mismatch, %s: expected %0d, got %0d (pixel %0d)",
				what, want, got, n_pixels);
	endfunction

	// checker: compare each returned pixel with the oldest prediction
	always @(posedge clk) begin : check_pixels
		out_item_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			n_pixels++;
			if (expected_pixels.size() == 0) begin
				flag_mismatch("pixel with none pending", 0, out_data.pixel);
			end else begin
				want = expected_pixels.pop_front();
				if (out_data.pixel !== want.pixel)
					flag_mismatch("pixel", want.pixel, out_data.pixel);
				if (out_data.last_pixel !== want.last_pixel)
					flag_mismatch("last_pixel", want.last_pixel, out_data.last_pixel);
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			case (idle_phase)
				PH_RECV: out_ready = ($urandom_range(99) >= 82);
				PH_BOTH: out_ready = ($urandom_range(99) >= 14);
				default: out_ready = 1'b1;
			endcase
		end
	end

	initial begin
		#30_000_000;
		$display("[waveform_autoscale_to_plot] ERROR");
		$finish;
	end

	task automatic drive_transaction(input in_item_t it);
		out_item_t px;
		idle_phase = (n_sent / PHASE_LEN) % 4;
		while ((idle_phase == PH_SEND && $urandom_range(99) < 82) ||
		       (idle_phase == PH_BOTH && $urandom_range(99) < 14)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (predict_pixel(it, px))
			expected_pixels.push_back(px);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_pixels();
		in_valid = 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		wait_for_pixels();
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_MODE)
			cfg_mode = val[0];
		else
			cfg_height = val;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input fill_t fill,
		input logic signed [SAMPLE_W-1:0] centre);
		case (fill)
			FILL_NARROW:   return SAMPLE_W'(int'(centre) + int'($urandom_range(0, 40)));
			FILL_FLAT:     return centre;
			FILL_MOST_NEG: return 16'sh8000;
			default:       return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic load_frame(input fill_t fill, input int noise_pct);
		logic signed [SAMPLE_W-1:0] centre;
		in_item_t it;
		centre = SAMPLE_W'($urandom);
		for (int i = 0; i < FRAME_POINTS; i++) begin
			if ($urandom_range(99) < noise_pct) begin
				it.kind   = KIND_EMIT;
				it.sample = SAMPLE_W'($urandom);
				drive_transaction(it);
			end
			it.kind   = KIND_LOAD;
			it.sample = pick_sample(fill, centre);
			drive_transaction(it);
		end
	endtask

	task automatic emit_window(input int count, input int drain_pct);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < drain_pct)
				wait_for_pixels();
			it.kind   = KIND_EMIT;
			it.sample = SAMPLE_W'($urandom);
			drive_transaction(it);
		end
	endtask

	task automatic test_emit_before_frame();
		in_item_t it;
		it.kind = KIND_EMIT;
		for (int b = 0; b < SAMPLE_W; b += 4) begin
			it.sample = SAMPLE_W'(1) << b;
			drive_transaction(it);
		end
		it.sample = 16'sh7FFF;
		drive_transaction(it);
		it.sample = 16'shFFFF;
		drive_transaction(it);
		settle();
	endtask

	task automatic test_middle_period_extremes();
		in_item_t it;
		write_reg(REG_MODE, CFG_DATA_W'(1));
		write_reg(REG_HEIGHT, 8'd255);
		for (int i = 0; i < FRAME_POINTS; i++) begin
			it.kind = KIND_LOAD;
			case (i)
				0:                   it.sample = 16'sh7FFF;
				PERIOD_POINTS:       it.sample = 16'sh8000;
				PERIOD_POINTS + 1:   it.sample = 16'sh7FFF;
				PERIOD_POINTS + 2:   it.sample = 16'sh0000;
				PERIOD_POINTS + 3:   it.sample = 16'shFFFF;
				PERIOD_POINTS + 4:   it.sample = 16'sh0001;
				FRAME_POINTS - 1:    it.sample = 16'sh8000;
				default:             it.sample = SAMPLE_W'($urandom);
			endcase
			drive_transaction(it);
			// switch mode mid-frame; the window keeps the latched mode
			if (i == 0) begin
				settle();
				write_reg(REG_MODE, CFG_DATA_W'(0));
			end
			if (i == 400) begin
				it.kind = KIND_EMIT;
				drive_transaction(it);
			end
		end
		it.kind = KIND_LOAD;
		it.sample = 16'sh8000;
		drive_transaction(it);
		it.sample = 16'sh7FFF;
		drive_transaction(it);
		emit_window(PERIOD_POINTS, 0);
		emit_window(1, 0);
		settle();
	endtask

	task automatic test_random_frames();
		int         frame;
		bit         mode;
		logic [7:0] height;
		fill_t      fill;
		in_item_t   it;
		frame = 0;
		while (n_sent < RANDOM_ITEMS) begin
			mode = (frame == 0) ? 1'b0 : 1'($urandom_range(1));
			height = $urandom_range(1) ? 8'd255 : 8'($urandom_range(1, 254));
			fill = (frame < 3) ? fill_t'(frame) : fill_t'($urandom_range(2));
			write_reg(REG_MODE, CFG_DATA_W'(mode));
			write_reg(REG_HEIGHT, height);
			load_frame(fill, 3);
			repeat ($urandom_range(3)) begin
				it.kind   = KIND_LOAD;
				it.sample = SAMPLE_W'($urandom);
				drive_transaction(it);
			end
			emit_window(window_len(mode), 2);
			settle();
			frame++;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		idle_phase = PH_NONE;
		clear_window();
		win_mode   = 1'b0;
		cfg_mode   = 1'b0;
		cfg_height = HEIGHT_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_emit_before_frame();
		test_middle_period_extremes();
		test_random_frames();

		in_valid = 1'b0;
		for (int c = 0; c < 5000 && expected_pixels.size() != 0; c++)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
		if (expected_pixels.size() != 0)
			flag_mismatch("pixels never returned", expected_pixels.size(), 0);

		$display("sent %0d transactions, checked %0d pixels, %0d mismatches",
			n_sent, n_pixels, n_mismatch);
		$display("frames shown: %0d with three periods, %0d with the middle period",
			frames_by_mode[0], frames_by_mode[1]);
		if (n_mismatch == 0)
			$display("[waveform_autoscale_to_plot] OK");
		else
			$display("[waveform_autoscale_to_plot] ERROR");
		$finish;
	end

endmodule
